@@ hw/rtl/kmer_node_presence_penalty_unit_assert.svh @@
// Assertion macros shared by the RTL of the presence penalty unit.
`ifndef KMER_NODE_PRESENCE_PENALTY_UNIT_ASSERT_SVH
`define KMER_NODE_PRESENCE_PENALTY_UNIT_ASSERT_SVH

// Clocked assertion that is ignored while reset is active.
`define KMPP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Clocked assertion that also holds during reset.
`define KMPP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);

`endif

@@ hw/rtl/kmpp_pkg.sv @@
package kmpp_pkg;

    localparam int RECORDS_DEF    = 65536;
    localparam int ASSEMBLIES_DEF = 4096;

    localparam logic [16:0] ONE_Q16 = 17'h10000;
    localparam logic [16:0] PEN_MAX = 17'h1FFFF;

    // Configuration register indexes.
    localparam logic [1:0] REG_TARGET    = 2'd0;
    localparam logic [1:0] REG_NONTARGET = 2'd1;
    localparam logic [1:0] REG_RECORDS   = 2'd2;

    localparam logic KIND_NODE   = 1'b0;
    localparam logic KIND_FINISH = 1'b1;

    typedef enum logic [1:0] {
        CMD_LOAD   = 2'd0,
        CMD_KMER   = 2'd1,
        CMD_EMPTY  = 2'd2,
        CMD_FINISH = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_RANGE = 2'd1,
        STAT_ORDER = 2'd2,
        STAT_NOTGT = 2'd3
    } status_t;

    typedef struct packed {
        cmd_t        cmd;
        logic [15:0] record_index;
        logic [15:0] assembly_last_record;
        logic        assembly_is_target;
        logic        node_first;
        logic        node_last;
    } in_t;

    typedef struct packed {
        logic        result_kind;
        status_t     status;
        logic [12:0] target_count;
        logic [12:0] nontarget_count;
        logic [16:0] penalty;
        logic [16:0] expected_target_absence;
        logic [16:0] expected_nontarget_presence;
    } out_t;

    // Divider request and status.
    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [47:0] divisor;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_sts_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_KMER,
        ST_NODE_END,
        ST_DIVT_GO,
        ST_DIVT_WAIT,
        ST_DIVN_GO,
        ST_DIVN_WAIT,
        ST_MUL_DD,
        ST_MUL_FF,
        ST_MUL_FT,
        ST_MUL_FN,
        ST_ACC,
        ST_SQRT,
        ST_FIN,
        ST_FQ_GO,
        ST_FQ_WAIT,
        ST_FR_GO,
        ST_FR_WAIT,
        ST_EMIT
    } state_t;

endpackage

@@ hw/rtl/kmer_node_presence_penalty_unit.sv @@
// Load word: written in idle. K-mer word: table read, then tally update.
// Node-closing k-mer word (straight to output on an error): two divider passes,
// four multiplies on one shared multiplier, an accumulate step and a square root.
// Finish word: two divider passes, skipped when no target k-mers were counted.
// Empty node word: sent straight to output. A finished result waits in place until m_ready.
// Synchronous reset clears control, tallies and sums, sets config to 1, 1, 65536.
module kmer_node_presence_penalty_unit
    import kmpp_pkg::*;
#(
    parameter int RECORDS    = RECORDS_DEF,
    parameter int ASSEMBLIES = ASSEMBLIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  in_t         s_data,
    output logic        m_valid,
    input  logic        m_ready,
    output out_t        m_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [16:0] cfg_data
);

`include "kmer_node_presence_penalty_unit_assert.svh"

    localparam int DEPTH = (RECORDS > 65536) ? 65536 : RECORDS;
    localparam int AW    = $clog2(DEPTH);
    localparam logic [12:0] TCAP = 13'((ASSEMBLIES < 8191) ? ASSEMBLIES : 8191);

    state_t state_reg, state_next;

    // Configuration registers.
    logic [12:0] tdiv_reg, ndiv_reg;
    logic [16:0] rcount_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tdiv_reg   <= 13'd1;
            ndiv_reg   <= 13'd1;
            rcount_reg <= 17'h10000;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TARGET:    tdiv_reg   <= cfg_data[12:0];
                REG_NONTARGET: ndiv_reg   <= cfg_data[12:0];
                REG_RECORDS:   rcount_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Record table: last record of the assembly and the target flag.
    logic [16:0] mem [DEPTH];
    logic [16:0] rd_reg;
    logic        accept;
    logic        mem_we;

    assign accept = s_valid && s_ready;
    assign mem_we = accept && (s_data.cmd == CMD_LOAD)
                    && (32'(s_data.record_index) < 32'(RECORDS));

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[s_data.record_index[AW-1:0]] <=
                {s_data.assembly_last_record, s_data.assembly_is_target};
        end
        rd_reg <= mem[s_data.record_index[AW-1:0]];
    end

    // Accepted word.
    in_t item_reg;

    always_ff @(posedge aclk) begin
        if (accept) begin
            item_reg <= s_data;
        end
    end

    // Node tally state.
    logic [15:0] prev_reg, prev_next;
    logic [15:0] aend_reg, aend_next;
    logic [12:0] tcnt_reg, tcnt_next;
    logic [12:0] ncnt_reg, ncnt_next;
    status_t     err_reg, err_next;
    logic        rec_ok;
    logic        do_count;

    always_comb begin
        rec_ok    = (17'(item_reg.record_index) < rcount_reg)
                    && (32'(item_reg.record_index) < 32'(RECORDS));
        prev_next = prev_reg;
        aend_next = aend_reg;
        tcnt_next = tcnt_reg;
        ncnt_next = ncnt_reg;
        err_next  = err_reg;
        do_count  = 1'b0;
        if (item_reg.node_first) begin
            err_next  = STAT_OK;
            tcnt_next = '0;
            ncnt_next = '0;
            prev_next = item_reg.record_index;
            if (!rec_ok) begin
                err_next = STAT_RANGE;
            end else begin
                do_count = 1'b1;
            end
        end else if (err_reg == STAT_OK) begin
            if (item_reg.record_index < prev_reg) begin
                err_next = STAT_ORDER;
            end else begin
                prev_next = item_reg.record_index;
                if (item_reg.record_index > aend_reg) begin
                    if (!rec_ok) begin
                        err_next = STAT_RANGE;
                    end else begin
                        do_count = 1'b1;
                    end
                end
            end
        end
        // A new assembly is counted on its first record.
        if (do_count) begin
            aend_next = rd_reg[16:1];
            if (rd_reg[0]) begin
                if (tcnt_next < TCAP) begin
                    tcnt_next = tcnt_next + 13'd1;
                end
            end else begin
                if (ncnt_next < TCAP) begin
                    ncnt_next = ncnt_next + 13'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_reg <= '0;
            aend_reg <= '0;
            tcnt_reg <= '0;
            ncnt_reg <= '0;
            err_reg  <= STAT_OK;
        end else if (state_reg == ST_KMER) begin
            prev_reg <= prev_next;
            aend_reg <= aend_next;
            tcnt_reg <= tcnt_next;
            ncnt_reg <= ncnt_next;
            err_reg  <= err_next;
        end
    end

    // Shared divider.
    div_ctl_t    div_ctl;
    div_sts_t    div_sts;
    logic [63:0] div_q;

    kmpp_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctl      (div_ctl),
        .sts      (div_sts),
        .quotient (div_q)
    );

    // Datapath registers.
    logic [29:0] ft_reg, fn_reg, d_val;
    logic [29:0] mul_a, mul_b;
    logic [59:0] prod_reg;
    logic [60:0] sq_reg;
    logic [47:0] tsum_reg;
    logic [63:0] tpsum_reg, npsum_reg;
    logic [63:0] v_reg, res_reg, bit_reg, rb;
    logic [16:0] q_reg;
    logic [48:0] tsum_add;
    logic [64:0] tp_add, np_add;
    logic [12:0] tdiv_eff, ndiv_eff;
    logic        out_free;
    out_t        pend_reg;

    assign tdiv_eff = (tdiv_reg == '0) ? 13'd1 : tdiv_reg;
    assign ndiv_eff = (ndiv_reg == '0) ? 13'd1 : ndiv_reg;
    assign d_val    = (ft_reg > 30'(ONE_Q16)) ? ft_reg - 30'(ONE_Q16)
                                               : 30'(ONE_Q16) - ft_reg;
    assign tsum_add = {1'b0, tsum_reg} + 49'(tcnt_reg);
    assign tp_add   = {1'b0, tpsum_reg} + 65'(prod_reg);
    assign np_add   = {1'b0, npsum_reg} + 65'(prod_reg);
    assign rb       = res_reg + bit_reg;
    assign out_free = !m_valid || m_ready;

    // Next state.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    case (s_data.cmd)
                        CMD_LOAD:   state_next = ST_IDLE;
                        CMD_KMER:   state_next = ST_KMER;
                        CMD_EMPTY:  state_next = ST_EMIT;
                        CMD_FINISH: state_next = ST_FIN;
                        default:    state_next = ST_IDLE;
                    endcase
                end
            end
            ST_KMER:      state_next = item_reg.node_last ? ST_NODE_END : ST_IDLE;
            ST_NODE_END:  state_next = (err_reg != STAT_OK) ? ST_EMIT : ST_DIVT_GO;
            ST_DIVT_GO:   state_next = ST_DIVT_WAIT;
            ST_DIVT_WAIT: state_next = div_sts.done ? ST_DIVN_GO : ST_DIVT_WAIT;
            ST_DIVN_GO:   state_next = ST_DIVN_WAIT;
            ST_DIVN_WAIT: state_next = div_sts.done ? ST_MUL_DD : ST_DIVN_WAIT;
            ST_MUL_DD:    state_next = ST_MUL_FF;
            ST_MUL_FF:    state_next = ST_MUL_FT;
            ST_MUL_FT:    state_next = ST_MUL_FN;
            ST_MUL_FN:    state_next = ST_ACC;
            ST_ACC:       state_next = ST_SQRT;
            ST_SQRT:      state_next = (bit_reg == '0) ? ST_EMIT : ST_SQRT;
            ST_FIN:       state_next = (tsum_reg == '0) ? ST_EMIT : ST_FQ_GO;
            ST_FQ_GO:     state_next = ST_FQ_WAIT;
            ST_FQ_WAIT:   state_next = div_sts.done ? ST_FR_GO : ST_FQ_WAIT;
            ST_FR_GO:     state_next = ST_FR_WAIT;
            ST_FR_WAIT:   state_next = div_sts.done ? ST_EMIT : ST_FR_WAIT;
            ST_EMIT:      state_next = out_free ? ST_IDLE : ST_EMIT;
            default:      state_next = ST_IDLE;
        endcase
    end

    // Sequencer outputs: handshake, divider requests, multiplier operands.
    always_comb begin
        s_ready          = 1'b0;
        div_ctl.start    = 1'b0;
        div_ctl.dividend = '0;
        div_ctl.divisor  = 48'd1;
        mul_a            = '0;
        mul_b            = '0;
        case (state_reg)
            ST_IDLE: s_ready = 1'b1;
            ST_DIVT_GO: begin
                div_ctl.start    = 1'b1;
                div_ctl.dividend = 64'({tcnt_reg, 16'h0000});
                div_ctl.divisor  = 48'(tdiv_eff);
            end
            ST_DIVN_GO: begin
                div_ctl.start    = 1'b1;
                div_ctl.dividend = 64'({ncnt_reg, 16'h0000});
                div_ctl.divisor  = 48'(ndiv_eff);
            end
            ST_FQ_GO: begin
                div_ctl.start    = 1'b1;
                div_ctl.dividend = tpsum_reg;
                div_ctl.divisor  = tsum_reg;
            end
            ST_FR_GO: begin
                div_ctl.start    = 1'b1;
                div_ctl.dividend = npsum_reg;
                div_ctl.divisor  = tsum_reg;
            end
            ST_MUL_DD: begin
                mul_a = d_val;
                mul_b = d_val;
            end
            ST_MUL_FF: begin
                mul_a = fn_reg;
                mul_b = fn_reg;
            end
            ST_MUL_FT: begin
                mul_a = ft_reg;
                mul_b = 30'(tcnt_reg);
            end
            ST_MUL_FN: begin
                mul_a = fn_reg;
                mul_b = 30'(tcnt_reg);
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Arithmetic steps of the node and finish sequences.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (!aresetn) begin
            tsum_reg  <= '0;
            tpsum_reg <= '0;
            npsum_reg <= '0;
        end else begin
            if (state_reg == ST_MUL_FN) begin
                tsum_reg  <= tsum_add[48] ? '1 : tsum_add[47:0];
                tpsum_reg <= tp_add[64] ? '1 : tp_add[63:0];
            end
            if (state_reg == ST_ACC) begin
                npsum_reg <= np_add[64] ? '1 : np_add[63:0];
            end
        end
        case (state_reg)
            ST_DIVT_WAIT: if (div_sts.done) ft_reg <= div_q[29:0];
            ST_DIVN_WAIT: if (div_sts.done) fn_reg <= div_q[29:0];
            ST_MUL_FF:    sq_reg <= 61'(prod_reg);
            ST_MUL_FT:    sq_reg <= sq_reg + 61'(prod_reg);
            ST_MUL_FN: begin
                v_reg   <= 64'(sq_reg);
                res_reg <= '0;
                bit_reg <= 64'h4000_0000_0000_0000;
            end
            ST_SQRT: begin
                if (bit_reg != '0) begin
                    if (v_reg >= rb) begin
                        v_reg   <= v_reg - rb;
                        res_reg <= (res_reg >> 1) + bit_reg;
                    end else begin
                        res_reg <= res_reg >> 1;
                    end
                    bit_reg <= bit_reg >> 2;
                end
            end
            ST_FQ_WAIT: begin
                if (div_sts.done) begin
                    q_reg <= (div_q > 64'(ONE_Q16)) ? ONE_Q16 : div_q[16:0];
                end
            end
            default: ;
        endcase
    end

    // Pending result word, built whole where each sequence ends.
    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && accept) begin
            pend_reg <= '{result_kind: KIND_NODE, status: STAT_OK,
                          target_count: '0, nontarget_count: '0, penalty: ONE_Q16,
                          expected_target_absence: '0, expected_nontarget_presence: '0};
        end else if (state_reg == ST_NODE_END && err_reg != STAT_OK) begin
            pend_reg <= '{result_kind: KIND_NODE, status: err_reg,
                          target_count: '0, nontarget_count: '0, penalty: '0,
                          expected_target_absence: '0, expected_nontarget_presence: '0};
        end else if (state_reg == ST_SQRT && bit_reg == '0) begin
            pend_reg <= '{result_kind: KIND_NODE, status: STAT_OK,
                          target_count: tcnt_reg, nontarget_count: ncnt_reg,
                          penalty: (res_reg > 64'(PEN_MAX)) ? PEN_MAX : res_reg[16:0],
                          expected_target_absence: '0, expected_nontarget_presence: '0};
        end else if (state_reg == ST_FIN) begin
            pend_reg <= '{result_kind: KIND_FINISH,
                          status: (tsum_reg == '0) ? STAT_NOTGT : STAT_OK,
                          target_count: '0, nontarget_count: '0, penalty: '0,
                          expected_target_absence: '0, expected_nontarget_presence: '0};
        end else if (state_reg == ST_FR_WAIT && div_sts.done) begin
            pend_reg <= '{result_kind: KIND_FINISH, status: STAT_OK,
                          target_count: '0, nontarget_count: '0, penalty: '0,
                          expected_target_absence: ONE_Q16 - q_reg,
                          expected_nontarget_presence:
                              (div_q > 64'(ONE_Q16)) ? ONE_Q16 : div_q[16:0]};
        end
    end

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (state_reg == ST_EMIT && out_free) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
        if (state_reg == ST_EMIT && out_free) begin
            m_data <= pend_reg;
        end
    end

    `KMPP_ASSERT(a_err_zero_counts,
        (m_valid && m_data.result_kind == KIND_NODE && m_data.status != STAT_OK)
        |-> (m_data.target_count == '0 && m_data.nontarget_count == '0),
        "node error word carries nonzero counts")
    `KMPP_ASSERT(a_idle_div_quiet, (state_reg == ST_IDLE) |-> !div_sts.busy,
        "divider busy while sequencer idle")
    `KMPP_ASSERT(a_load_one_cycle,
        (accept && s_data.cmd == CMD_LOAD) |=> (state_reg == ST_IDLE),
        "load word did not finish in one cycle")
    `KMPP_ASSERT_ALWAYS(a_reset_idle, !aresetn |=> (state_reg == ST_IDLE && !m_valid),
        "reset did not return the sequencer to idle")

endmodule

@@ hw/rtl/kmpp_div.sv @@
module kmpp_div
    import kmpp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  div_ctl_t ctl,
    output div_sts_t sts,
    output logic [63:0] quotient
);

    logic        busy_reg, busy_next;
    logic        done_reg, done_next;
    logic [6:0]  cnt_reg, cnt_next;
    logic [63:0] quo_reg, quo_next;
    logic [47:0] rem_reg, rem_next;
    logic [47:0] dvs_reg, dvs_next;
    logic [48:0] rem_sh;
    logic        ge;

    // One quotient bit per cycle, restoring form.
    always_comb begin
        rem_sh    = {rem_reg, quo_reg[63]};
        ge        = (rem_sh >= {1'b0, dvs_reg});
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        if (ctl.start) begin
            busy_next = 1'b1;
            cnt_next  = 7'd64;
            quo_next  = ctl.dividend;
            rem_next  = '0;
            dvs_next  = ctl.divisor;
        end else if (busy_reg) begin
            quo_next = {quo_reg[62:0], ge};
            rem_next = ge ? 48'(rem_sh - {1'b0, dvs_reg}) : rem_sh[47:0];
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
    end

    assign sts.busy = busy_reg;
    assign sts.done = done_reg;
    assign quotient = quo_reg;

endmodule

@@ tb/kmer_node_presence_penalty_unit_test.sv @@
module kmer_node_presence_penalty_unit_test;
    import kmpp_pkg::*;

    localparam int TALLY_LIMIT = 4096;
    localparam int STALL_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 400;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    in_t         s_data = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    out_t        m_data;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = '0;
    logic [16:0] cfg_data = '0;

    kmer_node_presence_penalty_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #2 aclk = 1'b1;
        #2 aclk = 1'b0;
    end

    // Shadow state of the block.
    logic [12:0] tgt_cfg, non_cfg;
    logic [16:0] rec_cfg;
    logic [15:0] last_tab [0:65535];
    logic        tgt_tab [0:65535];
    logic [15:0] prev_rec, asm_end;
    logic [12:0] tally_t, tally_n;
    logic [1:0]  node_err;
    logic [47:0] sum_total;
    logic [63:0] sum_tpres, sum_npres;

    in_t   word_queue [$];
    out_t  result_queue [$];
    int    errors = 0;
    int    sent = 0;
    int    received = 0;
    int    src_idle = 8;
    int    dst_idle = 66;
    int    quiet = 0;
    int    finishes = 0;
    logic  s_taken = 1'b0;

    // Host-side table of what has been loaded, for building valid nodes.
    logic  loaded [0:65535];

    function automatic logic [63:0] isqrt(logic [63:0] v);
        logic [63:0] res, bitv;
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        return (s < a) ? '1 : s;
    endfunction

    function automatic logic rec_ok(logic [15:0] idx);
        return {1'b0, idx} < rec_cfg;
    endfunction

    task automatic tally_record(logic [15:0] idx);
        asm_end = last_tab[idx];
        if (tgt_tab[idx]) begin
            if (tally_t < TALLY_LIMIT) tally_t++;
        end else begin
            if (tally_n < TALLY_LIMIT) tally_n++;
        end
    endtask

    // Append one word to the pending input queue.
    task automatic enqueue_word(in_t w);
        word_queue = {word_queue, w};
    endtask

    // Predict the result of one accepted word.
    task automatic predict_word(in_t w);
        out_t r;
        logic [63:0] tdiv, ndiv, ft, fn, d, p, q, rr;
        r = '0;
        case (w.cmd)
            CMD_LOAD: begin
                last_tab[w.record_index] = w.assembly_last_record;
                tgt_tab[w.record_index] = w.assembly_is_target;
            end
            CMD_EMPTY: begin
                r.penalty = ONE_Q16;
                result_queue = {result_queue, r};
            end
            CMD_FINISH: begin
                finishes++;
                r.result_kind = KIND_FINISH;
                if (sum_total == 0) begin
                    r.status = STAT_NOTGT;
                end else begin
                    q = sum_tpres / {16'd0, sum_total};
                    rr = sum_npres / {16'd0, sum_total};
                    if (q > 65536) q = 65536;
                    if (rr > 65536) rr = 65536;
                    r.expected_target_absence = 17'(65536 - q);
                    r.expected_nontarget_presence = 17'(rr);
                end
                result_queue = {result_queue, r};
            end
            default: begin
                if (w.node_first) begin
                    node_err = STAT_OK;
                    tally_t = 0;
                    tally_n = 0;
                    prev_rec = w.record_index;
                    if (!rec_ok(w.record_index)) node_err = STAT_RANGE;
                    else tally_record(w.record_index);
                end else if (node_err == STAT_OK) begin
                    if (w.record_index < prev_rec) begin
                        node_err = STAT_ORDER;
                    end else begin
                        prev_rec = w.record_index;
                        if (w.record_index > asm_end) begin
                            if (!rec_ok(w.record_index)) node_err = STAT_RANGE;
                            else tally_record(w.record_index);
                        end
                    end
                end
                if (w.node_last) begin
                    r.status = status_t'(node_err);
                    if (node_err == STAT_OK) begin
                        tdiv = (tgt_cfg == 0) ? 1 : tgt_cfg;
                        ndiv = (non_cfg == 0) ? 1 : non_cfg;
                        ft = ({51'd0, tally_t} << 16) / tdiv;
                        fn = ({51'd0, tally_n} << 16) / ndiv;
                        d = (ft > 65536) ? ft - 65536 : 65536 - ft;
                        p = isqrt(d * d + fn * fn);
                        if (p > 131071) p = 131071;
                        r.target_count = tally_t;
                        r.nontarget_count = tally_n;
                        r.penalty = 17'(p);
                        if ({16'd0, sum_total} + tally_t > 64'hFFFF_FFFF_FFFF)
                            sum_total = '1;
                        else
                            sum_total = sum_total + tally_t;
                        sum_tpres = add_sat(sum_tpres, ft * tally_t);
                        sum_npres = add_sat(sum_npres, fn * tally_t);
                    end
                    result_queue = {result_queue, r};
                end
            end
        endcase
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("mismatch on result %0d: %s got %0d, expected %0d",
                 received, what, got, want);
        errors++;
    endtask

    // Input side: each word is predicted at the edge that accepts it.
    always @(posedge aclk) begin
        s_taken <= aresetn && s_valid && s_ready;
        if (aresetn && s_valid && s_ready) begin
            predict_word(s_data);
            sent++;
        end
    end

    // Driver: presents queued words at the falling edge.
    always @(negedge aclk) begin
        if (!s_valid || s_taken) begin
            if (word_queue.size() > 0 && $urandom_range(99, 0) >= src_idle) begin
                s_valid <= 1'b1;
                s_data <= word_queue.pop_front();
            end else begin
                s_valid <= 1'b0;
            end
        end
        m_ready <= ($urandom_range(99, 0) >= dst_idle);
    end

    // Monitor: checks each accepted result word against the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (result_queue.size() == 0) begin
                $display("unexpected result word %0d", received);
                errors++;
            end else begin
                out_t e;
                e = result_queue.pop_front();
                if (m_data.result_kind !== e.result_kind)
                    report_mismatch("result_kind", 64'(m_data.result_kind),
                                    64'(e.result_kind));
                if (m_data.status !== e.status)
                    report_mismatch("status", 64'(m_data.status), 64'(e.status));
                if (m_data.target_count !== e.target_count)
                    report_mismatch("target_count", 64'(m_data.target_count),
                                    64'(e.target_count));
                if (m_data.nontarget_count !== e.nontarget_count)
                    report_mismatch("nontarget_count", 64'(m_data.nontarget_count),
                                    64'(e.nontarget_count));
                if (m_data.penalty !== e.penalty)
                    report_mismatch("penalty", 64'(m_data.penalty), 64'(e.penalty));
                if (m_data.expected_target_absence !== e.expected_target_absence)
                    report_mismatch("target absence", 64'(m_data.expected_target_absence),
                                    64'(e.expected_target_absence));
                if (m_data.expected_nontarget_presence !== e.expected_nontarget_presence)
                    report_mismatch("nontarget presence",
                                    64'(m_data.expected_nontarget_presence),
                                    64'(e.expected_nontarget_presence));
            end
            received++;
        end
    end

    // Watchdog on cycles without any accepted word.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)
            || !aresetn)
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= STALL_LIMIT) begin
            $display("watchdog expired: %0d words still expected", result_queue.size());
            $display("[kmer_node_presence_penalty_unit] ERROR");
            $finish;
        end
    end

    task automatic write_reg(logic [1:0] idx, logic [16:0] val);
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_TARGET:    tgt_cfg = val[12:0];
            REG_NONTARGET: non_cfg = val[12:0];
            default:       rec_cfg = val;
        endcase
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drain();
        while (word_queue.size() > 0 || s_valid || result_queue.size() > 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    function automatic in_t make_word(cmd_t c, logic [15:0] idx, logic [15:0] lst,
                                      logic tg, logic f, logic l);
        in_t w;
        w.cmd = c;
        w.record_index = idx;
        w.assembly_last_record = lst;
        w.assembly_is_target = tg;
        w.node_first = f;
        w.node_last = l;
        return w;
    endfunction

    // Load records 0..n-1 in assemblies of random length.
    task automatic queue_table(int n);
        int base, len, k;
        base = 0;
        while (base < n) begin
            logic tg;
            len = $urandom_range(4, 1);
            if (base + len > n) len = n - base;
            tg = 1'($urandom_range(1, 0));
            for (k = base; k < base + len; k++) begin
                enqueue_word(make_word(CMD_LOAD, 16'(k), 16'(base + len - 1), tg,
                                       1'($urandom_range(1, 0)),
                                       1'($urandom_range(1, 0))));
                loaded[k] = 1'b1;
            end
            base += len;
        end
    endtask

    // A well-formed node over loaded records, sometimes broken.
    task automatic queue_node(int span);
        int len, k;
        logic [15:0] r;
        len = $urandom_range(6, 1);
        r = 16'($urandom_range(span - 1, 0));
        for (k = 0; k < len; k++) begin
            logic [15:0] idx;
            idx = r;
            if ($urandom_range(29, 0) == 0 && k > 0) idx = (r > 0) ? r - 16'd1 : r;
            else if ($urandom_range(39, 0) == 0) idx = 16'($urandom_range(65535, span));
            if (!loaded[idx]) idx = r;
            enqueue_word(make_word(CMD_KMER, idx, 16'($urandom), 1'($urandom_range(1, 0)),
                                   k == 0, k == len - 1));
            if (r + 3 < span) r = r + 16'($urandom_range(3, 0));
        end
    endtask

    initial begin
        int phase, n, span;
        logic [12:0] tvals [3];
        logic [12:0] nvals [3];
        tvals = '{13'd1, 13'd4096, 13'd7};
        nvals = '{13'd4096, 13'd1, 13'd5};
        tgt_cfg = 1; non_cfg = 1; rec_cfg = 65536;
        prev_rec = 0; asm_end = 0; tally_t = 0; tally_n = 0; node_err = 0;
        sum_total = 0; sum_tpres = 0; sum_npres = 0;
        for (int i = 0; i < 65536; i++) loaded[i] = 1'b0;
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed: extremes of the table and every command.
        span = 64;
        queue_table(span);
        enqueue_word(make_word(CMD_LOAD, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 1'b1));
        loaded[65535] = 1'b1;
        enqueue_word(make_word(CMD_FINISH, 0, 0, 0, 0, 0));
        enqueue_word(make_word(CMD_EMPTY, 16'hFFFF, 16'hFFFF, 1, 1, 1));
        enqueue_word(make_word(CMD_KMER, 0, 0, 0, 1, 0));
        enqueue_word(make_word(CMD_KMER, 5, 0, 0, 0, 0));
        enqueue_word(make_word(CMD_KMER, 16'hFFFF, 16'hFFFF, 1, 0, 1));
        enqueue_word(make_word(CMD_KMER, 10, 0, 0, 1, 0));
        enqueue_word(make_word(CMD_KMER, 3, 0, 0, 0, 0));
        enqueue_word(make_word(CMD_KMER, 20, 0, 0, 0, 1));
        enqueue_word(make_word(CMD_KMER, 30, 0, 0, 0, 1));
        enqueue_word(make_word(CMD_FINISH, 0, 0, 0, 0, 0));
        wait_drain();

        // Out-of-range records with a small valid count.
        write_reg(REG_RECORDS, 17'd16);
        enqueue_word(make_word(CMD_KMER, 16, 0, 0, 1, 1));
        enqueue_word(make_word(CMD_KMER, 2, 0, 0, 1, 0));
        enqueue_word(make_word(CMD_KMER, 40, 0, 0, 0, 1));
        wait_drain();

        // Random phases over several settings and idling mixes.
        for (phase = 0; phase < 9; phase++) begin
            if (phase == 3) begin src_idle = 66; dst_idle = 8; end
            if (phase == 6) begin src_idle = 0; dst_idle = 0; end
            write_reg(REG_TARGET, (phase == 4) ? 17'd0 : 17'(tvals[phase % 3]));
            write_reg(REG_NONTARGET, (phase == 5) ? 17'd0 : 17'(nvals[phase % 3]));
            write_reg(REG_RECORDS, (phase % 3 == 0) ? 17'd65536 :
                                   (phase % 3 == 1) ? 17'd1 : 17'd48);
            n = 0;
            while (n < 240) begin
                int pick;
                pick = $urandom_range(99, 0);
                if (pick < 80) begin
                    queue_node(span);
                    n += 4;
                end else if (pick < 88) begin
                    enqueue_word(make_word(CMD_EMPTY, 16'($urandom), 16'($urandom),
                                           1'($urandom_range(1, 0)),
                                           1'($urandom_range(1, 0)),
                                           1'($urandom_range(1, 0))));
                    n++;
                end else if (pick < 94) begin
                    enqueue_word(make_word(CMD_FINISH, 16'($urandom), 16'($urandom),
                                           1'($urandom_range(1, 0)),
                                           1'($urandom_range(1, 0)),
                                           1'($urandom_range(1, 0))));
                    n++;
                end else begin
                    // Loose occurrence continuing whatever node is open.
                    logic [15:0] idx;
                    idx = 16'($urandom_range(span - 1, 0));
                    enqueue_word(make_word(CMD_KMER, idx, 16'($urandom),
                                           1'($urandom_range(1, 0)), 1'b0,
                                           1'($urandom_range(1, 0))));
                    n++;
                end
            end
            wait_drain();
        end

        $display("covered %0d input words and %0d result words, %0d finish words,",
                 sent, received, finishes);
        $display("over several divisor and record limits with mixed idling on both sides");
        if (errors == 0) begin
            $display("[kmer_node_presence_penalty_unit] OK");
        end else begin
            $display("[kmer_node_presence_penalty_unit] ERROR");
        end
        $finish;
    end
endmodule

@@ sim.f @@
+incdir+hw/rtl
hw/rtl/kmpp_pkg.sv
hw/rtl/kmpp_div.sv
hw/rtl/kmer_node_presence_penalty_unit.sv
tb/kmer_node_presence_penalty_unit_test.sv
